// ----- rtl/byte_ring_fifo_with_putback_macros.svh -----
// ----------------------------------------------------------------------------
// byte ring fifo assertion macros
// clocked assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_PUTBACK_MACROS_SVH
`define BYTE_RING_FIFO_WITH_PUTBACK_MACROS_SVH

// property checked on every rising edge outside reset
`define BRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define BRF_ASSERT_IMPL(label, ante, cons, msg) \
    `BRF_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// shared types and constants of the byte ring fifo with put-back
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int BRF_DEPTH     = 1024;
    localparam int BRF_MAX_BURST = 64;

    localparam int REQ_W  = 2;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 11;
    localparam int FILL_W = 10;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [SIZE_W-1:0] BUF_SIZE_RST = 11'd1024;

    localparam logic [ADDR_W-1:0] REG_BUFFER_SIZE = 3'd0;

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_STORE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RETRIEVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PUTBACK  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FLUSH    = 2'd3;

    // classified operations passed from front to back
    localparam logic [2:0] OP_BAD   = 3'd0;
    localparam logic [2:0] OP_STORE = 3'd1;
    localparam logic [2:0] OP_RETR  = 3'd2;
    localparam logic [2:0] OP_PUTB  = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic              first_byte;
        logic              last_byte;
        logic              reject;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
    } t_cmd;

endpackage

// ----- rtl/brf_front.sv -----
// ----------------------------------------------------------------------------
// brf_front
// accepts requests, tracks store bursts and classifies each transaction
// ----------------------------------------------------------------------------
module brf_front #(
    parameter int MAX_BURST = brf_pkg::BRF_MAX_BURST
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_clear,
    input  logic                       i_in_valid,
    input  logic [brf_pkg::REQ_W-1:0]  i_req_type,
    input  logic [brf_pkg::LEN_W-1:0]  i_length,
    input  logic [brf_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [brf_pkg::SIZE_W-1:0] i_size,
    input  logic                       i_q_full,
    output logic                       o_in_stall,
    output logic                       o_push,
    output brf_pkg::t_cmd              o_cmd
);
    import brf_pkg::*;

    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] n_rem;
    t_cmd             cmd;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_cmd      = cmd;

    always_comb begin
        cmd            = '0;
        cmd.op         = OP_FLUSH;
        cmd.len        = i_length;
        cmd.data       = i_data_byte;
        n_rem          = '0;
        case (i_req_type)
            REQ_STORE: begin
                if (r_rem == '0) begin
                    if (i_length == '0 || i_length > LEN_W'(MAX_BURST)) begin
                        cmd.op     = OP_BAD;
                        cmd.reject = 1'b1;
                    end else begin
                        cmd.op         = OP_STORE;
                        cmd.first_byte = 1'b1;
                        cmd.last_byte  = (i_length == LEN_W'(1));
                        n_rem          = i_length - LEN_W'(1);
                    end
                end else begin
                    cmd.op        = OP_STORE;
                    cmd.last_byte = (r_rem == LEN_W'(1));
                    n_rem         = r_rem - LEN_W'(1);
                end
            end
            REQ_RETRIEVE: begin
                cmd.op     = OP_RETR;
                cmd.reject = (i_length > LEN_W'(MAX_BURST));
            end
            REQ_PUTBACK: begin
                cmd.op     = OP_PUTB;
                cmd.reject = ({{(SIZE_W-LEN_W){1'b0}}, i_length} > i_size);
            end
            default: begin
                cmd.op = OP_FLUSH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_clear) begin
            r_rem <= '0;
        end else if (o_push) begin
            r_rem <= n_rem;
        end
    end

endmodule

// ----- rtl/brf_queue.sv -----
// ----------------------------------------------------------------------------
// brf_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module brf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output brf_pkg::t_cmd o_cmd
);
    import brf_pkg::*;

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/brf_back.sv -----
// ----------------------------------------------------------------------------
// brf_back
// executes commands on the ring: byte store, indices and result register
// ----------------------------------------------------------------------------
module brf_back #(
    parameter int DEPTH = brf_pkg::BRF_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_clear,
    input  logic [brf_pkg::SIZE_W-1:0] i_size,
    input  logic                       i_cmd_valid,
    input  brf_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_status,
    output logic [brf_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last,
    output logic [brf_pkg::FILL_W-1:0] o_fill_level,
    output logic [brf_pkg::SIZE_W-1:0] o_room_left
);
    import brf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    function automatic logic [CW-1:0] ring_fill(
        input logic [CW-1:0] h,
        input logic [CW-1:0] t,
        input logic [CW-1:0] s
    );
        if (h >= t) begin
            return h - t;
        end
        return h + s - t;
    endfunction

    logic [BYTE_W-1:0] mem [DEPTH];

    logic              r_state;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_tail;
    logic              r_acc;
    logic [AW-1:0]     r_rd_idx;
    logic [LEN_W-1:0]  r_issue_cnt;
    logic [LEN_W-1:0]  r_emit_cnt;
    logic              r_rd_vld;
    logic [BYTE_W-1:0] r_rd_data;
    logic [FILL_W-1:0] r_run_fill;
    logic [SIZE_W-1:0] r_run_room;
    logic              r_out_valid;
    logic              r_status;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_last;
    logic [FILL_W-1:0] r_fill;
    logic [SIZE_W-1:0] r_room;

    logic              n_state;
    logic [AW-1:0]     n_head;
    logic [AW-1:0]     n_tail;
    logic              n_acc;
    logic              n_rd_vld;

    logic [CW-1:0]     sz_c;
    logic [CW-1:0]     head_c;
    logic [CW-1:0]     tail_c;
    logic [CW-1:0]     len_c;
    logic [CW-1:0]     fill_c;
    logic [CW-1:0]     room_c;
    logic [CW-1:0]     fill_n;
    logic [CW-1:0]     head_inc;
    logic [CW-1:0]     tail_fwd;
    logic [CW-1:0]     tail_back;
    logic [CW-1:0]     run_fill_c;
    logic [CW-1:0]     rd_inc;
    logic              out_free;
    logic              acc_eff;
    logic              retr_reject;
    logic              pop;
    logic              res_load;
    logic              res_status;
    logic              mem_we;
    logic              mem_re;
    logic              byte_load;
    logic              run_start;

    assign sz_c     = CW'(i_size);
    assign head_c   = CW'(r_head);
    assign tail_c   = CW'(r_tail);
    assign len_c    = CW'(i_cmd.len);
    assign fill_c   = ring_fill(head_c, tail_c, sz_c);
    assign room_c   = sz_c - fill_c;
    assign out_free = !r_out_valid || !i_out_stall;

    assign head_inc   = head_c + CW'(1);
    assign tail_fwd   = tail_c + len_c;
    assign tail_back  = tail_c + sz_c - len_c;
    assign run_fill_c = fill_c - len_c;
    assign rd_inc     = CW'(r_rd_idx) + CW'(1);

    assign acc_eff     = i_cmd.first_byte ? (len_c < room_c) : r_acc;
    assign retr_reject = i_cmd.reject || (len_c > fill_c);

    always_comb begin
        pop        = 1'b0;
        res_load   = 1'b0;
        res_status = 1'b0;
        mem_we     = 1'b0;
        run_start  = 1'b0;
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_acc      = r_acc;
        if (r_state == ST_IDLE && i_cmd_valid) begin
            case (i_cmd.op)
                OP_STORE: begin
                    pop = !i_cmd.last_byte || out_free;
                    if (pop) begin
                        n_acc = i_cmd.last_byte ? 1'b0 : acc_eff;
                        if (acc_eff) begin
                            mem_we = 1'b1;
                            n_head = (head_inc >= sz_c) ? '0 : AW'(head_inc);
                        end
                        res_load   = i_cmd.last_byte;
                        res_status = !acc_eff;
                    end
                end
                OP_RETR: begin
                    n_acc = 1'b0;
                    if (retr_reject || i_cmd.len == '0) begin
                        pop        = out_free;
                        res_load   = out_free;
                        res_status = retr_reject;
                    end else begin
                        pop       = 1'b1;
                        run_start = 1'b1;
                        n_state   = ST_RUN;
                        n_tail    = (tail_fwd >= sz_c) ? AW'(tail_fwd - sz_c) : AW'(tail_fwd);
                    end
                end
                OP_PUTB: begin
                    n_acc      = 1'b0;
                    pop        = out_free;
                    res_load   = out_free;
                    res_status = i_cmd.reject;
                    if (out_free && !i_cmd.reject) begin
                        n_tail = (tail_back >= sz_c) ? AW'(tail_back - sz_c) : AW'(tail_back);
                    end
                end
                OP_FLUSH: begin
                    n_acc    = 1'b0;
                    pop      = out_free;
                    res_load = out_free;
                    if (out_free) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                end
                default: begin
                    pop        = out_free;
                    res_load   = out_free;
                    res_status = 1'b1;
                end
            endcase
        end
    end

    assign fill_n = ring_fill(CW'(n_head), CW'(n_tail), sz_c);

    assign byte_load = (r_state == ST_RUN) && r_rd_vld && out_free;
    assign mem_re    = (r_state == ST_RUN) && (r_issue_cnt != '0) && (!r_rd_vld || byte_load);
    assign n_rd_vld  = mem_re || (r_rd_vld && !byte_load);
    assign o_cmd_pop = pop;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_head] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (run_start) begin
            r_run_fill <= FILL_W'(run_fill_c);
            r_run_room <= SIZE_W'(sz_c - run_fill_c);
        end
        if (res_load) begin
            r_status   <= res_status;
            r_out_byte <= '0;
            r_last     <= 1'b1;
            r_fill     <= FILL_W'(fill_n);
            r_room     <= SIZE_W'(sz_c - fill_n);
        end else if (byte_load) begin
            r_status   <= 1'b0;
            r_out_byte <= r_rd_data;
            r_last     <= (r_emit_cnt == LEN_W'(1));
            r_fill     <= r_run_fill;
            r_room     <= r_run_room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_clear) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_acc       <= 1'b0;
            r_rd_idx    <= '0;
            r_issue_cnt <= '0;
            r_emit_cnt  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_acc       <= n_acc;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= res_load || byte_load || (r_out_valid && i_out_stall);
            if (run_start) begin
                r_state     <= ST_RUN;
                r_rd_idx    <= r_tail;
                r_issue_cnt <= i_cmd.len;
                r_emit_cnt  <= i_cmd.len;
            end else begin
                r_state <= n_state;
                if (mem_re) begin
                    r_rd_idx    <= (rd_inc >= sz_c) ? '0 : AW'(rd_inc);
                    r_issue_cnt <= r_issue_cnt - LEN_W'(1);
                end
                if (byte_load) begin
                    r_emit_cnt <= r_emit_cnt - LEN_W'(1);
                    if (r_emit_cnt == LEN_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_out_byte   = r_out_byte;
    assign o_last       = r_last;
    assign o_fill_level = r_fill;
    assign o_room_left  = r_room;

endmodule

// ----- rtl/byte_ring_fifo_with_putback.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_putback
// results: a status result passes the command queue and the result register;
//   the first byte of a retrieve also passes the read data register
// throughput: unless stalled, one store byte per cycle; a retrieve emits one byte
//   per cycle once its run has started, bounded by the store's single read port
// reset: sync active low, clears indices and burst state, size back to 1024
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_putback #(
    parameter int DEPTH     = brf_pkg::BRF_DEPTH,
    parameter int MAX_BURST = brf_pkg::BRF_MAX_BURST
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [brf_pkg::ADDR_W-1:0] paddr,
    input  logic [brf_pkg::DATA_W-1:0] pwdata,
    output logic [brf_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [brf_pkg::REQ_W-1:0]  i_req_type,
    input  logic [brf_pkg::LEN_W-1:0]  i_length,
    input  logic [brf_pkg::BYTE_W-1:0] i_data_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_status,
    output logic [brf_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last,
    output logic [brf_pkg::FILL_W-1:0] o_fill_level,
    output logic [brf_pkg::SIZE_W-1:0] o_room_left
);
    import brf_pkg::*;

    localparam int SZ_MAX = (DEPTH < 2047) ? DEPTH : 2047;

    logic [SIZE_W-1:0] r_buffer_size;
    logic [SIZE_W-1:0] ring_sz;
    logic              cfg_wr;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;
    t_cmd              front_cmd;
    t_cmd              q_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_BUFFER_SIZE);
    assign prdata = (paddr == REG_BUFFER_SIZE) ? DATA_W'(r_buffer_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUF_SIZE_RST;
        end else if (cfg_wr) begin
            r_buffer_size <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb begin
        if (r_buffer_size > SIZE_W'(SZ_MAX)) begin
            ring_sz = SIZE_W'(SZ_MAX);
        end else if (r_buffer_size < SIZE_W'(2)) begin
            ring_sz = SIZE_W'(2);
        end else begin
            ring_sz = r_buffer_size;
        end
    end

    brf_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_clear (cfg_wr),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_length    (i_length),
        .i_data_byte (i_data_byte),
        .i_size      (ring_sz),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    brf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    brf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_clear  (cfg_wr),
        .i_size       (ring_sz),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_fill_level (o_fill_level),
        .o_room_left  (o_room_left)
    );

endmodule

// ----- rtl/brf_checker.sv -----
// ----------------------------------------------------------------------------
// brf_checker
// port-level checks of the byte ring fifo, bound to the top level
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_with_putback_macros.svh"

module brf_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic                       o_status,
    input  logic [brf_pkg::BYTE_W-1:0] o_out_byte,
    input  logic                       o_last,
    input  logic [brf_pkg::FILL_W-1:0] o_fill_level,
    input  logic [brf_pkg::SIZE_W-1:0] o_room_left
);
    import brf_pkg::*;

    // one slot always stays empty
    `BRF_ASSERT_IMPL(a_room_nonzero, o_out_valid, o_room_left != '0, "room_left is zero")

    // only retrieved bytes come without last, and they are never rejected
    `BRF_ASSERT_IMPL(a_mid_run_ok, o_out_valid && !o_last, !o_status, "rejected mid-run result")

    // a rejection is a single result with no data
    `BRF_ASSERT_IMPL(a_reject_shape, o_out_valid && o_status, o_out_byte == '0 && o_last, "bad reject result")

    // a stalled transaction holds
    `BRF_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte) && $stable(o_fill_level) && $stable(o_last), "output changed under stall")

endmodule

bind byte_ring_fifo_with_putback brf_checker u_brf_checker (.*);
